// ----- rtl/core/hed_pkg.sv -----
package hed_pkg;

    localparam int LookaheadDef = 12;
    localparam int NameCount    = 36;
    localparam int NameMax      = 6;

    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChHash  = 8'h23;
    localparam logic [7:0] ChXLow  = 8'h78;
    localparam logic [7:0] ChXUp   = 8'h58;
    localparam logic [31:0] CpMax  = 32'h0010_FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } t_out;

    typedef enum logic [1:0] {
        ESEL_FLUSH = 2'd0,
        ESEL_FRESH = 2'd1,
        ESEL_UTF   = 2'd2
    } t_esel;

    typedef struct packed {
        logic  capture;
        logic  open_ref;
        logic  store;
        logic  close;
        logic  decode;
        logic  emit;
        t_esel sel;
        logic  final_item;
        logic  idx_inc;
        logic  idx_clr;
    } t_cmd;

    typedef struct packed {
        logic pending;
        logic last;
        logic is_amp;
        logic is_semi;
        logic is_end;
        logic flush_done;
        logic utf_done;
        logic cp_ok;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic        found;
        logic [20:0] code;
    } t_name_hit;

    // Names are right aligned: the first character sits in the highest used byte.
    localparam logic [47:0] NameText [NameCount] = '{
        48'("amp"), 48'("lt"), 48'("gt"), 48'("quot"), 48'("apos"), 48'("nbsp"),
        48'("rsquo"), 48'("lsquo"), 48'("rdquo"), 48'("ldquo"), 48'("ndash"),
        48'("mdash"), 48'("hellip"), 48'("reg"), 48'("trade"), 48'("copy"),
        48'("bull"), 48'("middot"), 48'("deg"), 48'("eacute"), 48'("euro"),
        48'("pound"), 48'("cent"), 48'("sect"), 48'("para"), 48'("times"),
        48'("frac12"), 48'("shy"), 48'("ensp"), 48'("emsp"), 48'("thinsp"),
        48'("zwnj"), 48'("zwj"), 48'("iexcl"), 48'("laquo"), 48'("raquo")
    };

    localparam logic [2:0] NameLen [NameCount] = '{
        3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd6, 3'd3, 3'd5, 3'd4, 3'd4, 3'd6, 3'd3, 3'd6, 3'd4, 3'd5, 3'd4, 3'd4,
        3'd4, 3'd5, 3'd6, 3'd3, 3'd4, 3'd4, 3'd6, 3'd4, 3'd3, 3'd5, 3'd5, 3'd5
    };

    localparam logic [20:0] NameCode [NameCount] = '{
        21'h26, 21'h3C, 21'h3E, 21'h22, 21'h27, 21'hA0, 21'h2019, 21'h2018,
        21'h201D, 21'h201C, 21'h2013, 21'h2014, 21'h2026, 21'hAE, 21'h2122,
        21'hA9, 21'h2022, 21'hB7, 21'hB0, 21'hE9, 21'h20AC, 21'hA3, 21'hA2,
        21'hA7, 21'hB6, 21'hD7, 21'hBD, 21'hAD, 21'h2002, 21'h2003, 21'h2009,
        21'h200C, 21'h200D, 21'hA1, 21'hAB, 21'hBB
    };

    // win holds body byte j at win[8*j +: 8].
    function automatic t_name_hit name_lookup(input logic [47:0] win, input logic [7:0] len);
        t_name_hit hit;
        logic      match;
        int        nl;
        hit = '0;
        for (int k = 0; k < NameCount; k++) begin
            nl    = int'(NameLen[k]);
            match = (len == 8'(NameLen[k]));
            for (int j = 0; j < NameMax; j++) begin
                if (j < nl && win[8*j +: 8] != NameText[k][8*(nl-1-j) +: 8]) begin
                    match = 1'b0;
                end
            end
            if (match) begin
                hit.found = 1'b1;
                hit.code  = NameCode[k];
            end
        end
        return hit;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B
            || c == 8'h0C || c == 8'h0D;
    endfunction

endpackage

// ----- rtl/core/html_entity_decoder.sv -----
// Streaming HTML character reference decoder with UTF-8 output. One item is
// taken at a time: a plain byte is passed on, a byte held in an open reference
// is stored, a reference ended early by an ampersand, whitespace or a full body
// and a semicolon that fails to decode both flush the ampersand and the held
// bytes, and a decoded reference goes out as its UTF-8 bytes. An item that ends
// the stream with a reference still open flushes the held bytes as well. The
// controller moves one output byte per cycle through a single output register
// while the output does not stall.
module html_entity_decoder #(
    parameter int Lookahead = hed_pkg::LookaheadDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hed_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output hed_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    hed_pkg::t_cmd cmd;
    hed_pkg::t_sts sts;

    hed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    hed_dp #(
        .Lookahead (Lookahead)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("a second item was taken while one was in work");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("output register loaded while its byte was still stalled");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.text_end) |-> o_out_data.run_last)
        else $error("stream end marked on a byte that does not end its item");

endmodule

// ----- rtl/core/hed_ctrl.sv -----
module hed_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hed_pkg::t_sts i_sts,
    output hed_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_DECODE = 6'b000100,
        ST_UTF    = 6'b001000,
        ST_FLUSH  = 6'b010000,
        ST_FRESH  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_fresh, n_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fresh <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fresh    = r_fresh;
        o_cmd      = '0;
        o_cmd.sel  = hed_pkg::ESEL_FLUSH;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_sts.pending) begin
                    n_state = ST_FRESH;
                end else if (i_sts.is_semi) begin
                    n_state = ST_DECODE;
                end else if (i_sts.is_end) begin
                    n_fresh = 1'b1;
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.store = 1'b1;
                    n_fresh     = 1'b0;
                    n_state     = i_sts.last ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = ST_UTF;
            end
            ST_UTF: begin
                if (!i_sts.cp_ok) begin
                    n_fresh = 1'b1;
                    n_state = ST_FLUSH;
                end else if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.sel        = hed_pkg::ESEL_UTF;
                    o_cmd.final_item = i_sts.utf_done;
                    if (i_sts.utf_done) begin
                        o_cmd.close   = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.sel        = hed_pkg::ESEL_FLUSH;
                    // The last held byte ends the item unless the ending byte still goes out.
                    o_cmd.final_item = i_sts.flush_done
                        && (!r_fresh || (i_sts.is_amp && !i_sts.last));
                    if (i_sts.flush_done) begin
                        o_cmd.close   = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = r_fresh ? ST_FRESH : ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_FRESH: begin
                if (i_sts.is_amp) begin
                    o_cmd.open_ref = 1'b1;
                    n_fresh        = 1'b0;
                    n_state        = i_sts.last ? ST_FLUSH : ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.sel        = hed_pkg::ESEL_FRESH;
                    o_cmd.final_item = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/hed_dp.sv -----
module hed_dp #(
    parameter int Lookahead = hed_pkg::LookaheadDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hed_pkg::t_in  i_in_data,
    input  hed_pkg::t_cmd i_cmd,
    input  logic          i_out_stall,
    output hed_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output hed_pkg::t_out o_out_data
);

    localparam int BodyMax = Lookahead - 2;
    localparam int SW      = $clog2(BodyMax);
    localparam int CW      = $clog2(BodyMax + 1);

    logic [7:0]    r_c;
    logic          r_last;
    logic          r_pending;
    logic [7:0]    r_store [BodyMax];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [31:0]   r_dec;
    logic [31:0]   r_hex;
    logic          r_dec_ok;
    logic          r_hex_ok;
    logic [20:0]   r_cp;
    logic          r_cp_ok;
    logic          r_out_valid;
    hed_pkg::t_out r_out;

    logic          c_digit;
    logic          c_hex;
    logic [3:0]    c_hval;
    logic [47:0]   name_win;
    hed_pkg::t_name_hit name_hit;
    logic          n_cp_ok;
    logic [20:0]   n_cp;
    logic [31:0]   num_v;
    logic          num_ok;
    logic [2:0]    utf_len;
    logic [7:0]    utf_byte;
    logic [7:0]    flush_byte;
    logic [7:0]    emit_byte;
    logic          out_free;

    always_comb begin
        c_digit = (r_c >= 8'h30 && r_c <= 8'h39);
        c_hval  = 4'd0;
        c_hex   = 1'b1;
        if (c_digit) begin
            c_hval = r_c[3:0];
        end else if ((r_c >= 8'h61 && r_c <= 8'h66) || (r_c >= 8'h41 && r_c <= 8'h46)) begin
            c_hval = 4'(r_c[2:0] + 3'd1) + 4'd8;
        end else begin
            c_hex = 1'b0;
        end
    end

    for (genvar j = 0; j < hed_pkg::NameMax; j++) begin : g_win
        if (j < BodyMax) begin : g_on
            assign name_win[8*j +: 8] = r_store[j];
        end else begin : g_off
            assign name_win[8*j +: 8] = 8'h00;
        end
    end

    always_comb begin
        name_hit = hed_pkg::name_lookup(name_win, 8'(r_count));
        n_cp_ok  = 1'b0;
        n_cp     = name_hit.code;
        num_v    = r_dec;
        num_ok   = r_dec_ok;
        if (r_store[1] == hed_pkg::ChXLow || r_store[1] == hed_pkg::ChXUp) begin
            num_v  = r_hex;
            num_ok = r_hex_ok && (r_count >= CW'(3));
        end
        if (r_count == '0) begin
            n_cp_ok = 1'b0;
        end else if (r_store[0] == hed_pkg::ChHash) begin
            n_cp_ok = (r_count >= CW'(2)) && num_ok && (num_v != '0)
                && (num_v <= hed_pkg::CpMax);
            n_cp    = num_v[20:0];
        end else begin
            n_cp_ok = name_hit.found;
        end
    end

    always_comb begin
        if (r_cp < 21'h80) begin
            utf_len = 3'd1;
        end else if (r_cp < 21'h800) begin
            utf_len = 3'd2;
        end else if (r_cp < 21'h10000) begin
            utf_len = 3'd3;
        end else begin
            utf_len = 3'd4;
        end
        utf_byte = {2'b10, r_cp[5:0]};
        case ({utf_len, r_idx[1:0]})
            {3'd1, 2'd0}: utf_byte = {1'b0, r_cp[6:0]};
            {3'd2, 2'd0}: utf_byte = {3'b110, r_cp[10:6]};
            {3'd3, 2'd0}: utf_byte = {4'b1110, r_cp[15:12]};
            {3'd3, 2'd1}: utf_byte = {2'b10, r_cp[11:6]};
            {3'd4, 2'd0}: utf_byte = {5'b11110, r_cp[20:18]};
            {3'd4, 2'd1}: utf_byte = {2'b10, r_cp[17:12]};
            {3'd4, 2'd2}: utf_byte = {2'b10, r_cp[11:6]};
            default:      utf_byte = {2'b10, r_cp[5:0]};
        endcase
    end

    assign flush_byte = (r_idx == '0) ? hed_pkg::ChAmp : r_store[SW'(r_idx - CW'(1))];

    always_comb begin
        case (i_cmd.sel)
            hed_pkg::ESEL_FRESH: emit_byte = r_c;
            hed_pkg::ESEL_UTF:   emit_byte = utf_byte;
            default:             emit_byte = flush_byte;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_cp_ok     <= 1'b0;
        end else begin
            if (i_cmd.open_ref) begin
                r_pending <= 1'b1;
                r_count   <= '0;
            end else if (i_cmd.close) begin
                r_pending <= 1'b0;
                r_count   <= '0;
            end else if (i_cmd.store) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.decode) begin
                r_cp_ok <= n_cp_ok;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_c    <= i_in_data.in_byte;
            r_last <= i_in_data.in_last;
        end
        if (i_cmd.open_ref) begin
            r_dec    <= '0;
            r_hex    <= '0;
            r_dec_ok <= 1'b1;
            r_hex_ok <= 1'b1;
        end else if (i_cmd.store) begin
            r_store[SW'(r_count)] <= r_c;
            if (r_count >= CW'(1)) begin
                r_dec    <= (r_dec << 3) + (r_dec << 1) + {28'd0, c_digit ? r_c[3:0] : 4'd0};
                r_dec_ok <= r_dec_ok && c_digit;
            end
            if (r_count >= CW'(2)) begin
                r_hex    <= {r_hex[27:0], c_hval};
                r_hex_ok <= r_hex_ok && c_hex;
            end
        end
        if (i_cmd.decode) begin
            r_cp <= n_cp;
        end
        if (i_cmd.emit) begin
            r_out.out_byte <= emit_byte;
            r_out.run_last <= i_cmd.final_item;
            r_out.text_end <= i_cmd.final_item && r_last;
        end
    end

    always_comb begin
        o_sts.pending    = r_pending;
        o_sts.last       = r_last;
        o_sts.is_amp     = (r_c == hed_pkg::ChAmp);
        o_sts.is_semi    = (r_c == hed_pkg::ChSemi);
        o_sts.is_end     = (r_c == hed_pkg::ChAmp) || hed_pkg::is_white(r_c)
            || (r_count >= CW'(BodyMax));
        o_sts.flush_done = (r_idx == r_count);
        o_sts.utf_done   = (r_idx == CW'(utf_len - 3'd1));
        o_sts.cp_ok      = r_cp_ok;
        o_sts.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
